// ===== sv/transient_peak_suppressor_core_macros.svh =====
// Assertion macros shared by the transient peak suppressor RTL.
`ifndef TRANSIENT_PEAK_SUPPRESSOR_CORE_MACROS_SVH
`define TRANSIENT_PEAK_SUPPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tps_pkg.sv =====
// Package: widths, constants and codes of the transient peak suppressor.
`default_nettype none

package tps_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 24;
    localparam int COEFF_W    = 16;
    localparam int AMOUNT_W   = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Serial multiplier: 24-bit multiplicand, 17-bit multiplier, one bit per cycle
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // Serial divider: 24 quotient bits, 25-bit divisor
    localparam int DEN_W     = 25;
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Fixed-point constants (Q.23 magnitudes, Q1.16 amount)
    localparam logic [SAMPLE_W-1:0] THRESHOLD_Q23 = 24'h400000;
    localparam logic [SAMPLE_W-1:0] UNITY_Q23     = 24'h800000;
    localparam logic [DEN_W-1:0]    DEN_UNITY     = 25'h0800000;
    localparam logic [AMOUNT_W-1:0] AMOUNT_ONE    = 17'd65536;
    localparam logic [AMOUNT_W-1:0] AMOUNT_BYPASS = 17'd66;
    localparam logic [COEFF_W-1:0]  RELEASE_RESET = 16'd68;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELEASE = 2'd0,
        CFG_AMOUNT  = 2'd1
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== sv/tps_if.sv =====
// Stream interfaces: sample input and suppressed sample output.
`default_nettype none

interface tps_in_if import tps_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       reducing;

    modport source (output valid, output sample_out, output reducing, input ready);
    modport sink   (input valid, input sample_out, input reducing, output ready);
endinterface

`default_nettype wire

// ===== sv/tps_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module tps_serial_mul import tps_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic                    o_done,
    output logic [MUL_P_W-1:0]      o_prod
);

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_A_W:0]     w_sum;

    // Add the multiplicand when the low multiplier bit is set
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(MUL_A_W + 1){1'b0}});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial sum shifts right into the multiplier register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[MUL_A_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

// ===== sv/tps_serial_div.sv =====
// Restoring divider: floor(mag * 2^23 / den), one quotient bit per cycle.
`default_nettype none

module tps_serial_div import tps_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SAMPLE_W-1:0] i_mag,
    input  wire logic [DEN_W-1:0]    i_den,
    output logic                     o_done,
    output logic [SAMPLE_W-1:0]      o_quot
);

    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [SAMPLE_W-1:0]  r_num;
    logic [SAMPLE_W-1:0]  r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DEN_W:0]       w_trial;
    logic [DEN_W:0]       w_diff;
    logic                 w_ge;

    // Trial subtraction of the divisor from the shifted remainder
    assign w_trial = {r_rem, r_num[SAMPLE_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the top 23 dividend bits preload the remainder, the rest shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= {2'b00, i_mag[SAMPLE_W-1:1]};
            r_num  <= {i_mag[0], {(SAMPLE_W - 1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num  <= {r_num[SAMPLE_W-2:0], 1'b0};
            r_quot <= {r_quot[SAMPLE_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== sv/transient_peak_suppressor_core.sv =====
// Path: a bypassed sample goes straight to the output register; a reduced sample
// passes the serial release multiply (skipped on a rising peak), the serial
// overshoot multiply and the serial divide before it reaches the output register.
// The single bit-serial multiplier and divider hold one sample at a time, so no
// new sample is taken until the output register has loaded the last result.
// Reset (synchronous, active low): envelope 0, release coefficient 68, amount 0.
`default_nettype none
`include "transient_peak_suppressor_core_macros.svh"

module transient_peak_suppressor_core import tps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tps_in_if.sink                     i_in,
    tps_out_if.source                  o_out
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_REL   = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_OVR   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [COEFF_W-1:0]  r_coeff;
    logic [AMOUNT_W-1:0] r_amount;
    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] r_raw;
    logic [SAMPLE_W-1:0] r_mag;
    logic                r_neg;
    logic [SAMPLE_W-1:0] r_res;
    logic                r_red;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_red;

    logic [SAMPLE_W-1:0] w_raw;
    logic                w_neg;
    logic [SAMPLE_W-1:0] w_mag;
    logic [AMOUNT_W-1:0] w_amt;
    logic                w_bypass;
    logic                w_accept;
    logic                w_rise;
    logic                w_over_th;
    logic [SAMPLE_W-1:0] w_over;
    logic                w_out_load;

    logic                w_mul_start;
    logic [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0]  w_mul_b;
    logic                w_mul_done;
    logic [MUL_P_W-1:0]  w_prod;
    logic                w_div_start;
    logic [DEN_W-1:0]    w_den;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_quot;

    // Input decode: magnitude of the sample (2^23 for the most negative code)
    assign w_raw    = $unsigned(i_in.sample_in);
    assign w_neg    = w_raw[SAMPLE_W-1];
    assign w_mag    = w_neg ? (~w_raw + 1'b1) : w_raw;
    assign w_amt    = (r_amount > AMOUNT_ONE) ? AMOUNT_ONE : r_amount;
    assign w_bypass = (w_amt < AMOUNT_BYPASS);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_rise   = (w_mag > r_peak);

    // Envelope vs threshold
    assign w_over_th = (r_peak > THRESHOLD_Q23);
    assign w_over    = r_peak - THRESHOLD_Q23;

    // Shared multiplier: release decay in idle, overshoot times amount in check
    assign w_mul_start = (r_state == ST_IDLE && w_accept && !w_bypass && !w_rise)
                      || (r_state == ST_CHECK && w_over_th);
    assign w_mul_a     = (r_state == ST_IDLE) ? (r_peak - w_mag) : w_over;
    assign w_mul_b     = (r_state == ST_IDLE) ? {1'b0, r_coeff} : w_amt;

    // Divisor 1 + 2 * overshoot * amount in Q.23
    assign w_den       = DEN_UNITY + w_prod[MUL_P_W-2:MUL_P_W-1-DEN_W];
    assign w_div_start = (r_state == ST_OVR) && w_mul_done;

    tps_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    tps_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (r_mag),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff  <= RELEASE_RESET;
            r_amount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RELEASE: r_coeff  <= i_cfg_data[COEFF_W-1:0];
                CFG_AMOUNT:  r_amount <= i_cfg_data[AMOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_bypass) begin
                        n_state = ST_EMIT;
                    end else if (w_rise) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_state = ST_REL;
                    end
                end
            end
            ST_REL: begin
                if (w_mul_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = w_over_th ? ST_OVR : ST_EMIT;
            end
            ST_OVR: begin
                if (w_mul_done) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Peak envelope: jump up on a larger non-bypassed magnitude, decay by the release product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (r_state == ST_IDLE && w_accept && !w_bypass && w_rise) begin
            r_peak <= w_mag;
        end else if (r_state == ST_REL && w_mul_done) begin
            r_peak <= r_peak - w_prod[MUL_P_W-2:MUL_P_W-1-SAMPLE_W];
        end
    end

    // Per-sample working registers and result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_raw <= w_raw;
            r_neg <= w_neg;
            r_mag <= w_mag;
            r_res <= w_raw;
            r_red <= 1'b0;
        end else if (r_state == ST_CHECK && !w_over_th) begin
            r_res <= r_raw;
            r_red <= 1'b0;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_res <= r_neg ? (~w_quot + 1'b1) : w_quot;
            r_red <= 1'b1;
        end
    end

    // Output register
    assign w_out_load = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sample <= r_res;
            r_out_red    <= r_red;
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = $signed(r_out_sample);
    assign o_out.reducing   = r_out_red;

    // Checks
    `TPS_ASSERT_IMP(a_peak_bound, i_clk, i_rst_n, 1'b1, r_peak <= UNITY_Q23, "envelope above unity")
    `TPS_ASSERT_IMP(a_mul_owner, i_clk, i_rst_n, w_mul_done, (r_state == ST_REL) || (r_state == ST_OVR), "multiplier done outside a multiply step")
    `TPS_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "divider done outside the divide step")
    `TPS_ASSERT_NXT(a_no_reduce, i_clk, i_rst_n, (r_state == ST_CHECK) && !w_over_th, (r_state == ST_EMIT) && !r_red, "sample below threshold not passed through")

endmodule

`default_nettype wire
